/* rtl/fvas_pkg.sv */
// Shared types, codes, tables and helpers of the four-voice envelope synth.
package fvas_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LD, ST_DISP, ST_DIV, ST_PH1, ST_PHASE, ST_ENV, ST_WAVE,
    ST_MUL1, ST_MUL2, ST_SDIV, ST_SCALE, ST_WB, ST_NEXT, ST_OUT
  } state_e;

  // envelope stage codes
  localparam logic [2:0] ENV_IDLE    = 3'd0;
  localparam logic [2:0] ENV_ATTACK  = 3'd1;
  localparam logic [2:0] ENV_DECAY   = 3'd2;
  localparam logic [2:0] ENV_SUSTAIN = 3'd3;
  localparam logic [2:0] ENV_RELEASE = 3'd4;

  // register offsets within a voice block
  localparam logic [2:0] OFS_FREQ_LO = 3'd0;
  localparam logic [2:0] OFS_FREQ_HI = 3'd1;
  localparam logic [2:0] OFS_UNUSED  = 3'd2;
  localparam logic [2:0] OFS_ATK_DEC = 3'd3;
  localparam logic [2:0] OFS_SUS_REL = 3'd4;
  localparam logic [2:0] OFS_PW      = 3'd5;
  localparam logic [2:0] OFS_VOLUME  = 3'd6;
  localparam logic [2:0] OFS_CONTROL = 3'd7;

  // waveform codes
  localparam logic [3:0] WAVE_PULSE = 4'd1;
  localparam logic [3:0] WAVE_TRI   = 4'd2;
  localparam logic [3:0] WAVE_SAW   = 4'd3;
  localparam logic [3:0] WAVE_NOISE = 4'd4;

  // envelope step divider (divisor from the rate tables)
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DEN_W     = 21;
  localparam int unsigned CNT_W     = 6;
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(DIV_W);
  localparam logic [32:0]      GAIN_ONE  = 33'h1_0000_0000;

  // phase step: freq * 2^32 / 44100 = freq * 97391 + freq * 6049 / 11025
  localparam logic [16:0]  PHASE_WHOLE    = 17'd97391;
  localparam logic [12:0]  PHASE_FRAC_NUM = 13'd6049;
  // ceil(2^43 / 11025), exact for numerators below 2^29
  localparam logic [29:0]  PHASE_RECIP    = 30'd797831567;
  localparam int unsigned  PHASE_SHIFT    = 43;
  // ceil(2^19 / 15), exact for numerators below 2^15
  localparam logic [15:0]  SCALE_RECIP    = 16'd34953;
  localparam int unsigned  SCALE_SHIFT    = 19;

  typedef struct packed {
    logic [15:0] freq;
    logic [7:0]  atk_dec;
    logic [7:0]  sus_rel;
    logic [7:0]  pw;
    logic [7:0]  volume;
    logic [7:0]  control;
    logic [31:0] phase;
    logic [15:0] noise_reg;
    logic        gate_event;
    logic [2:0]  env_stage;
    logic [32:0] env_gain;
  } voice_t;

  function automatic logic [DEN_W-1:0] atk_len(input logic [3:0] n);
    logic [DEN_W-1:0] r;
    unique case (n)
      4'd0:  r = 21'd88;
      4'd1:  r = 21'd352;
      4'd2:  r = 21'd705;
      4'd3:  r = 21'd1058;
      4'd4:  r = 21'd1675;
      4'd5:  r = 21'd2469;
      4'd6:  r = 21'd2998;
      4'd7:  r = 21'd3528;
      4'd8:  r = 21'd4410;
      4'd9:  r = 21'd11025;
      4'd10: r = 21'd22050;
      4'd11: r = 21'd35280;
      4'd12: r = 21'd44100;
      4'd13: r = 21'd132300;
      4'd14: r = 21'd220500;
      default: r = 21'd352800;
    endcase
    return r;
  endfunction

  function automatic logic [DEN_W-1:0] dr_len(input logic [3:0] n);
    logic [DEN_W-1:0] r;
    unique case (n)
      4'd0:  r = 21'd264;
      4'd1:  r = 21'd1058;
      4'd2:  r = 21'd2116;
      4'd3:  r = 21'd3175;
      4'd4:  r = 21'd5027;
      4'd5:  r = 21'd7408;
      4'd6:  r = 21'd8996;
      4'd7:  r = 21'd10584;
      4'd8:  r = 21'd13230;
      4'd9:  r = 21'd33075;
      4'd10: r = 21'd66150;
      4'd11: r = 21'd105840;
      4'd12: r = 21'd132300;
      4'd13: r = 21'd396900;
      4'd14: r = 21'd661500;
      default: r = 21'd1058400;
    endcase
    return r;
  endfunction

  // floor(s * 2^32 / 15): 2^32 - 1 is 15 * 0x11111111
  function automatic logic [32:0] sus_level(input logic [3:0] s);
    return 33'(s) * 33'h1111_1111 + 33'(s == 4'hF);
  endfunction

  function automatic voice_t voice_init(input logic [1:0] sel);
    voice_t r;
    r = '0;
    unique case (sel)
      2'd0: r.noise_reg = 16'hACE1;
      2'd1: r.noise_reg = 16'hDEAD;
      2'd2: r.noise_reg = 16'hBEEF;
      default: r.noise_reg = 16'h1337;
    endcase
    return r;
  endfunction

endpackage

/* rtl/fvas_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fvas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/four_voice_adsr_synth.sv */
// Top level of the four-voice envelope synth: sequencer, divider and voice RAM.
//
// Input channel (in_valid_i/in_ready_o) carries one request at a time:
//   req_type_i = 0: byte write into the register block of voice voice_index_i
//     at reg_offset_i (0/1 freq, 3 atk/dec, 4 sus/rel, 5 pulse width,
//     6 volume, 7 control). Offset 2 and voices past VOICE_COUNT are dropped.
//   req_type_i = 1: sample tick; advances each voice of nonzero volume one
//     sample and returns the 16-bit wrapped mix on out_valid_o/out_ready_i.
// Voice state lives in one RAM (one word per voice, registered read). A write
// request read-modify-writes its voice word; a tick walks all voices the same
// way; only one request is in flight. A tick skips the update and write-back
// of a muted voice. A voice whose envelope is in attack, decay or release
// also waits on the shared 48-step restoring divider that forms the envelope
// step; phase step and volume scale use reciprocal multiplies.
// Reset: the valid bit of every RAM word clears; an unwritten word reads as
// the voice's power-on value (all zero, noise seed per voice). No sweep.
// Stall: the mix sits in an output register; a new request is accepted while
// it waits, and a following tick holds its result until the register frees.
module four_voice_adsr_synth #(
  parameter int unsigned VOICE_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [1:0]  voice_index_i,
  input  logic [2:0]  reg_offset_i,
  input  logic [7:0]  reg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] mixed_sample_o
);
  import fvas_pkg::*;

  localparam int unsigned VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  // sequencer state
  state_e state_q, state_d;
  state_e ret_q, ret_d;            // where to resume after a division
  logic [VW-1:0] v_q, v_d;         // voice being processed

  // latched request
  logic       typ_q;
  logic [2:0] ofs_q;
  logic [7:0] dat_q;

  // working copy of one voice word
  voice_t w_q, w_d;
  logic [15:0] acc_q, acc_d;       // running mix
  logic        raw_neg_q, raw_neg_d;
  logic [7:0]  raw_mag_q, raw_mag_d;
  logic [15:0] mag_q, mag_d;
  logic [47:0] prod_q, prod_d;
  logic [31:0] ph_step_q, ph_step_d;  // phase increment being built
  logic [28:0] ph_num_q, ph_num_d;    // freq * 6049
  logic [15:0] sc_q, sc_d;            // scaled voice magnitude

  // output register
  logic        out_valid_q;
  logic [15:0] out_data_q;
  logic        out_load;

  // RAM and per-word valid bits
  logic [VOICE_COUNT-1:0]    vld_q;
  logic                      ram_re, ram_we;
  logic [$bits(voice_t)-1:0] ram_rdata;

  // shared restoring divider: quotient shifts into num_q
  logic [DIV_W-1:0] div_num_q, div_num_in;
  logic [DEN_W-1:0] div_den_q, div_den_in;
  logic [DEN_W-1:0] div_rem_q;
  logic [CNT_W-1:0] div_cnt_q;
  logic             div_start;
  logic [DEN_W:0]   div_sh;
  logic             div_ge;

  logic [3:0] v_ext;
  logic       accept;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign accept         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign mixed_sample_o = out_data_q;
  assign v_ext          = 4'(v_q);

  fvas_ram #(
    .WIDTH ($bits(voice_t)),
    .DEPTH (VOICE_COUNT)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (v_q),
    .wdata_i (w_q),
    .re_i    (ram_re),
    .raddr_i (v_q),
    .rdata_o (ram_rdata)
  );

  // divider step
  assign div_sh = {div_rem_q, div_num_q[DIV_W-1]};
  assign div_ge = (div_sh >= {1'b0, div_den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (div_start) begin
      div_cnt_q <= DIV_STEPS;
    end else if (div_cnt_q != '0) begin
      div_cnt_q <= div_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      div_num_q <= div_num_in;
      div_den_q <= div_den_in;
      div_rem_q <= '0;
    end else if (div_cnt_q != '0) begin
      div_num_q <= {div_num_q[DIV_W-2:0], div_ge};
      div_rem_q <= div_ge ? DEN_W'(div_sh - {1'b0, div_den_q}) : div_sh[DEN_W-1:0];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      v_q         <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      v_q     <= v_d;
      if (ram_we) begin
        vld_q[v_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      typ_q <= req_type_i;
      ofs_q <= reg_offset_i;
      dat_q <= reg_data_i;
    end
    w_q       <= w_d;
    acc_q     <= acc_d;
    raw_neg_q <= raw_neg_d;
    raw_mag_q <= raw_mag_d;
    mag_q     <= mag_d;
    prod_q    <= prod_d;
    ph_step_q <= ph_step_d;
    ph_num_q  <= ph_num_d;
    sc_q      <= sc_d;
    if (out_load) begin
      out_data_q <= acc_q;
    end
  end

  // sequencer
  always_comb begin
    logic [32:0]      sus;
    logic [32:0]      inc;
    logic [33:0]      sum;
    logic [2:0]       stg;
    logic [7:0]       pos;
    logic signed [9:0] val;
    logic [15:0]      nz;
    logic             fb;
    logic [58:0]      ph_prod;
    logic [31:0]      sc_prod;

    state_d    = state_q;
    ret_d      = ret_q;
    v_d        = v_q;
    w_d        = w_q;
    acc_d      = acc_q;
    raw_neg_d  = raw_neg_q;
    raw_mag_d  = raw_mag_q;
    mag_d      = mag_q;
    prod_d     = prod_q;
    ph_step_d  = ph_step_q;
    ph_num_d   = ph_num_q;
    sc_d       = sc_q;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    div_start  = 1'b0;
    div_num_in = '0;
    div_den_in = '0;

    sus     = sus_level(w_q.sus_rel[7:4]);
    inc     = div_num_q[32:0];
    sum     = '0;
    stg     = w_q.env_stage;
    pos     = w_q.phase[31:24];
    val     = '0;
    nz      = w_q.noise_reg;
    fb      = 1'b0;
    ph_prod = '0;
    sc_prod = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i) begin
            v_d     = '0;
            acc_d   = '0;
            state_d = ST_RD;
          end else if (32'(voice_index_i) < VOICE_COUNT) begin
            v_d     = VW'(voice_index_i);
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        ram_re  = 1'b1;
        state_d = ST_LD;
      end
      ST_LD: begin
        w_d     = vld_q[v_q] ? voice_t'(ram_rdata) : voice_init(v_ext[1:0]);
        state_d = ST_DISP;
      end
      ST_DISP: begin
        if (!typ_q) begin
          unique case (ofs_q)
            OFS_FREQ_LO: w_d.freq[7:0]   = dat_q;
            OFS_FREQ_HI: w_d.freq[15:8]  = dat_q;
            OFS_UNUSED:  w_d             = w_q;
            OFS_ATK_DEC: w_d.atk_dec     = dat_q;
            OFS_SUS_REL: w_d.sus_rel     = dat_q;
            OFS_PW:      w_d.pw          = dat_q;
            OFS_VOLUME:  w_d.volume      = dat_q;
            OFS_CONTROL: begin
              if (w_q.control[7] != dat_q[7]) begin
                w_d.gate_event = 1'b1;
              end
              w_d.control = dat_q;
            end
            default: w_d = w_q;
          endcase
          state_d = ST_WB;
        end else if (w_q.volume == 8'd0) begin
          state_d = ST_NEXT;  // muted voice stays frozen
        end else begin
          // whole part of the phase step, wraps at 32 bits
          ph_step_d = 32'(33'(w_q.freq) * 33'(PHASE_WHOLE));
          ph_num_d  = 29'(w_q.freq) * 29'(PHASE_FRAC_NUM);
          state_d   = ST_PH1;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ret_q;
        end
      end
      ST_PH1: begin
        // fractional part: floor(freq * 6049 / 11025) by reciprocal
        ph_prod   = 59'(ph_num_q) * 59'(PHASE_RECIP);
        ph_step_d = ph_step_q + 32'(ph_prod[58:PHASE_SHIFT]);
        state_d   = ST_PHASE;
      end
      ST_PHASE: begin
        w_d.phase = w_q.phase + ph_step_q;
        if (w_q.gate_event) begin
          if (w_q.control[7]) begin
            w_d.env_gain = '0;
            stg          = ENV_ATTACK;
          end else begin
            stg = ENV_RELEASE;
          end
          w_d.gate_event = 1'b0;
        end
        w_d.env_stage = stg;
        ret_d         = ST_ENV;
        if (stg == ENV_ATTACK) begin
          div_start  = 1'b1;
          div_num_in = DIV_W'(GAIN_ONE);
          div_den_in = atk_len(w_q.atk_dec[7:4]);
          state_d    = ST_DIV;
        end else if (stg == ENV_DECAY) begin
          div_start  = 1'b1;
          div_num_in = DIV_W'(GAIN_ONE - sus);
          div_den_in = dr_len(w_q.atk_dec[3:0]);
          state_d    = ST_DIV;
        end else if (stg == ENV_RELEASE) begin
          div_start  = 1'b1;
          div_num_in = DIV_W'(sus);
          div_den_in = dr_len(w_q.sus_rel[3:0]);
          state_d    = ST_DIV;
        end else begin
          state_d = ST_WAVE;
        end
      end
      ST_ENV: begin
        if (w_q.env_stage == ENV_ATTACK) begin
          sum = {1'b0, w_q.env_gain} + {1'b0, inc};
          if (sum >= {1'b0, GAIN_ONE}) begin
            w_d.env_gain  = GAIN_ONE;
            w_d.env_stage = ENV_DECAY;
          end else begin
            w_d.env_gain = sum[32:0];
          end
        end else if (w_q.env_stage == ENV_DECAY) begin
          sum = {1'b0, sus} + {1'b0, inc};
          if ({1'b0, w_q.env_gain} <= sum) begin
            w_d.env_gain  = sus;
            w_d.env_stage = ENV_SUSTAIN;
          end else begin
            w_d.env_gain = w_q.env_gain - inc;
          end
        end else begin
          if (w_q.env_gain <= inc) begin
            w_d.env_gain  = '0;
            w_d.env_stage = ENV_IDLE;
          end else begin
            w_d.env_gain = w_q.env_gain - inc;
          end
        end
        state_d = ST_WAVE;
      end
      ST_WAVE: begin
        unique case (w_q.control[3:0])
          WAVE_PULSE: val = (pos < w_q.pw) ? 10'sd127 : -10'sd127;
          WAVE_TRI: begin
            if (!pos[7]) val = $signed({1'b0, pos, 1'b0}) - 10'sd127;
            else         val = 10'sd383 - $signed({1'b0, pos, 1'b0});
          end
          WAVE_SAW: begin
            nz[7:0] = 8'({pos, 1'b0} + 9'd129);
            val     = 10'($signed(nz[7:0]));
            nz      = w_q.noise_reg;
          end
          WAVE_NOISE: begin
            fb  = nz[0] ^ nz[2] ^ nz[3] ^ nz[5];
            nz  = {fb, nz[15:1]};
            val = nz[0] ? 10'sd127 : -10'sd127;
            w_d.noise_reg = nz;
          end
          default: val = '0;
        endcase
        raw_neg_d = val[9];
        raw_mag_d = val[9] ? 8'(-val) : val[7:0];
        state_d   = ST_MUL1;
      end
      ST_MUL1: begin
        mag_d   = 16'(raw_mag_q) * 16'(w_q.volume);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        prod_d  = 48'(mag_q) * 48'(w_q.env_gain);
        state_d = ST_SDIV;
      end
      ST_SDIV: begin
        // floor(prod / 2^32) stays below 2^15, so the reciprocal is exact
        sc_prod = 32'(prod_q[47:32]) * 32'(SCALE_RECIP);
        sc_d    = 16'(sc_prod[31:SCALE_SHIFT]);
        state_d = ST_SCALE;
      end
      ST_SCALE: begin
        acc_d   = acc_q + (raw_neg_q ? 16'(16'd0 - sc_q) : sc_q);
        state_d = ST_WB;
      end
      ST_WB: begin
        ram_we  = 1'b1;
        state_d = typ_q ? ST_NEXT : ST_IDLE;
      end
      ST_NEXT: begin
        if (32'(v_q) == VOICE_COUNT - 1) begin
          state_d = ST_OUT;
        end else begin
          v_d     = v_q + 1'b1;
          state_d = ST_RD;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* rtl/fvas_chk.sv */
// Port-level checker for the four-voice envelope synth, bound to the top.
module fvas_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        req_type_i,
  input logic [1:0]  voice_index_i,
  input logic [2:0]  reg_offset_i,
  input logic [7:0]  reg_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] mixed_sample_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mixed_sample_o))
    else $error("result changed while stalled");

  // a write request never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !req_type_i && !out_valid_o |=> !out_valid_o)
    else $error("write request produced a result");

  // a tick keeps the block busy
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && req_type_i |=> !in_ready_o)
    else $error("ready right after a tick request");

  // a new result only comes out of a busy period
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared while idle");

endmodule

bind four_voice_adsr_synth fvas_chk u_fvas_chk (.*);
